// ===== sv/tpmf_pkg.sv =====
// Shared types and constants for the serial touch packet median filter.
`timescale 1ns / 1ps

package tpmf_pkg;

   localparam int COORD_W   = 14;
   localparam int BYTE_W    = 8;
   localparam int DATA_W    = 7;
   localparam int TIMEOUT_W = 16;

   localparam int LEAD_BIT  = 7;
   localparam int PRESS_BIT = 6;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
   localparam logic [TIMEOUT_W-1:0] IDLE_MAX      = 16'hFFFF;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic KIND_TOUCH   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // completed packet from the parser
   typedef struct packed {
      logic               done;
      logic               press;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } pkt_type;

endpackage

// ===== sv/tpmf_parser.sv =====
// Byte parser: assembles lead byte plus four 7-bit data bytes into a packet.
`timescale 1ns / 1ps

module tpmf_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          byte_valid,
   input  logic [tpmf_pkg::BYTE_W-1:0]   data_byte,
   output tpmf_pkg::pkt_type             pkt
);
   import tpmf_pkg::*;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_XLO,
      PH_XHI,
      PH_YLO,
      PH_YHI
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [COORD_W-1:0] x_ff, x_in;
   logic [COORD_W-1:0] y_ff, y_in;
   logic               press_ff, press_in;
   logic [COORD_W-1:0] high_part;
   logic [COORD_W-1:0] low_part;

   assign low_part  = COORD_W'(data_byte[DATA_W-1:0]);
   assign high_part = {data_byte[DATA_W-1:0], {(COORD_W-DATA_W){1'b0}}};

   always_comb begin
      phase_in  = phase_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      press_in  = press_ff;
      pkt.done  = 1'b0;
      pkt.press = press_ff;
      pkt.x     = x_ff;
      pkt.y     = y_ff + high_part;
      if (byte_valid) begin
         if (data_byte[LEAD_BIT]) begin
            // lead byte restarts parsing, even mid packet
            phase_in = PH_XLO;
            x_in     = '0;
            y_in     = '0;
            press_in = data_byte[PRESS_BIT];
         end else begin
            case (phase_ff)
               PH_LEAD: begin
                  phase_in = PH_LEAD;
               end
               PH_XLO: begin
                  x_in     = low_part;
                  phase_in = PH_XHI;
               end
               PH_XHI: begin
                  x_in     = x_ff + high_part;
                  phase_in = PH_YLO;
               end
               PH_YLO: begin
                  y_in     = low_part;
                  phase_in = PH_YHI;
               end
               PH_YHI: begin
                  y_in     = y_ff + high_part;
                  phase_in = PH_LEAD;
                  pkt.done = 1'b1;
               end
               default: begin
                  phase_in = PH_LEAD;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         x_ff     <= '0;
         y_ff     <= '0;
         press_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         press_ff <= press_in;
      end
   end

endmodule

// ===== sv/tpmf_cell.sv =====
// Window cell: holds one x/y sample, shifts it on, and ranks its next value.
`timescale 1ns / 1ps

module tpmf_cell #(
   parameter int DEPTH = 5,
   parameter int INDEX = 0
) (
   input  logic                                    clock,
   input  logic                                    shift,
   input  logic [tpmf_pkg::COORD_W-1:0]            x_shift_in,
   input  logic [tpmf_pkg::COORD_W-1:0]            y_shift_in,
   input  logic [DEPTH-1:0][tpmf_pkg::COORD_W-1:0] win_x,
   input  logic [DEPTH-1:0][tpmf_pkg::COORD_W-1:0] win_y,
   output logic [tpmf_pkg::COORD_W-1:0]            x_q,
   output logic [tpmf_pkg::COORD_W-1:0]            y_q,
   output logic [tpmf_pkg::COORD_W-1:0]            x_next,
   output logic [tpmf_pkg::COORD_W-1:0]            y_next,
   output logic                                    x_pick,
   output logic                                    y_pick
);
   import tpmf_pkg::*;

   localparam int RANK_W = $clog2(DEPTH);
   localparam logic [RANK_W-1:0] MID = RANK_W'(DEPTH / 2);

   logic [COORD_W-1:0] x_ff, x_in;
   logic [COORD_W-1:0] y_ff, y_in;
   logic [RANK_W-1:0]  x_rank;
   logic [RANK_W-1:0]  y_rank;

   assign x_in   = shift ? x_shift_in : x_ff;
   assign y_in   = shift ? y_shift_in : y_ff;
   assign x_q    = x_ff;
   assign y_q    = y_ff;
   assign x_next = x_in;
   assign y_next = y_in;

   // rank = values below this one, ties broken by cell position
   always_comb begin
      x_rank = '0;
      y_rank = '0;
      for (int j = 0; j < DEPTH; j++) begin
         if (j != INDEX) begin
            if (win_x[j] < x_in || (win_x[j] == x_in && j < INDEX))
               x_rank = x_rank + 1'b1;
            if (win_y[j] < y_in || (win_y[j] == y_in && j < INDEX))
               y_rank = y_rank + 1'b1;
         end
      end
   end

   assign x_pick = (x_rank == MID);
   assign y_pick = (y_rank == MID);

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

endmodule

// ===== sv/serial_touch_packet_median_filter.sv =====
// Top level: serial touch packet decoder with a rolling median over a cell chain.
// Result: registered, on rsp_tvalid in the cycle after the transaction that produces it.
// Throughput: one transaction per cycle while req_tready is high; the window chain shifts and the
// rank compare across all cells completes within that cycle.
// req_tready drops only while a result waits and rsp_tready is low.
// Reset (synchronous, active high) clears parser, fill count, touch state,
// idle counter and output valid, and loads timeout_ticks with 100.
`timescale 1ns / 1ps

module serial_touch_packet_median_filter #(
   parameter int WINDOW_DEPTH = 5
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] op (0 = byte, 1 = tick)
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [13:0] pos_x, [27:14] pos_y, [31:28] zero
   output logic        rsp_tuser,   // [0] kind (0 = touch, 1 = release)
   // configuration: timeout_ticks
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [15:0] csr_tdata
);
   import tpmf_pkg::*;

   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam logic [FILL_W-1:0] FULL = FILL_W'(WINDOW_DEPTH);

   logic                accept;
   logic                byte_acc;
   logic                tick_acc;
   pkt_type             pkt;
   logic                push;

   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic                 down_ff, down_in;
   logic [TIMEOUT_W-1:0] idle_ff, idle_in;
   logic [TIMEOUT_W-1:0] idle_inc;
   logic [TIMEOUT_W-1:0] limit;
   logic [TIMEOUT_W-1:0] timeout_ff;

   logic                 emit;
   logic                 emit_kind;
   logic                 emit_median;
   logic [COORD_W-1:0]   med_x;
   logic [COORD_W-1:0]   med_y;

   logic                 rsp_valid_ff;
   logic                 rsp_kind_ff;
   logic [COORD_W-1:0]   rsp_x_ff;
   logic [COORD_W-1:0]   rsp_y_ff;

   logic [WINDOW_DEPTH-1:0][COORD_W-1:0] cell_x_q;
   logic [WINDOW_DEPTH-1:0][COORD_W-1:0] cell_y_q;
   logic [WINDOW_DEPTH-1:0][COORD_W-1:0] cell_x_next;
   logic [WINDOW_DEPTH-1:0][COORD_W-1:0] cell_y_next;
   logic [WINDOW_DEPTH-1:0]              cell_x_pick;
   logic [WINDOW_DEPTH-1:0]              cell_y_pick;

   // hold new transactions only while a result is stuck downstream
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign byte_acc   = accept && (req_tuser == OP_BYTE);
   assign tick_acc   = accept && (req_tuser == OP_TICK);
   assign csr_tready = 1'b1;

   tpmf_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_acc),
      .data_byte  (req_tdata),
      .pkt        (pkt)
   );

   // a finished press packet advances the window chain by one sample
   assign push = pkt.done && pkt.press;

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      logic [COORD_W-1:0] x_src;
      logic [COORD_W-1:0] y_src;
      if (i == 0) begin : g_head
         assign x_src = pkt.x;
         assign y_src = pkt.y;
      end else begin : g_link
         assign x_src = cell_x_q[i-1];
         assign y_src = cell_y_q[i-1];
      end
      tpmf_cell #(
         .DEPTH (WINDOW_DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .shift      (push),
         .x_shift_in (x_src),
         .y_shift_in (y_src),
         .win_x      (cell_x_next),
         .win_y      (cell_y_next),
         .x_q        (cell_x_q[i]),
         .y_q        (cell_y_q[i]),
         .x_next     (cell_x_next[i]),
         .y_next     (cell_y_next[i]),
         .x_pick     (cell_x_pick[i]),
         .y_pick     (cell_y_pick[i])
      );
   end

   // exactly one cell holds each median rank; OR the picked values together
   always_comb begin
      med_x = '0;
      med_y = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         if (cell_x_pick[i])
            med_x = med_x | cell_x_next[i];
         if (cell_y_pick[i])
            med_y = med_y | cell_y_next[i];
      end
   end

   assign limit    = (timeout_ff == '0) ? TIMEOUT_W'(1) : timeout_ff;
   assign idle_inc = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 1'b1;

   always_comb begin
      fill_in     = fill_ff;
      down_in     = down_ff;
      idle_in     = idle_ff;
      emit        = 1'b0;
      emit_kind   = KIND_TOUCH;
      emit_median = 1'b0;
      if (tick_acc) begin
         if (down_ff) begin
            idle_in = idle_inc;
            // idle run reached the limit: force a release
            if (idle_inc >= limit) begin
               fill_in   = '0;
               down_in   = 1'b0;
               idle_in   = '0;
               emit      = 1'b1;
               emit_kind = KIND_RELEASE;
            end
         end
      end else if (byte_acc) begin
         idle_in = '0;
         if (pkt.done) begin
            if (pkt.press) begin
               if (fill_ff < FULL)
                  fill_in = fill_ff + 1'b1;
               // report once the window holds a full set of samples
               if (fill_in >= FULL) begin
                  down_in     = 1'b1;
                  emit        = 1'b1;
                  emit_kind   = KIND_TOUCH;
                  emit_median = 1'b1;
               end
            end else begin
               // release packet: report it and drop the window
               fill_in   = '0;
               down_in   = 1'b0;
               emit      = 1'b1;
               emit_kind = KIND_RELEASE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         down_ff      <= 1'b0;
         idle_ff      <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         down_ff <= down_in;
         idle_ff <= idle_in;
         if (csr_tvalid && csr_tready)
            timeout_ff <= csr_tdata;
         if (emit)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // result payload; zero coordinates on release
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_x_ff    <= emit_median ? med_x : '0;
         rsp_y_ff    <= emit_median ? med_y : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {4'b0000, rsp_y_ff, rsp_x_ff};

endmodule
